>>> rtl/tkrb_pkg.sv
// shared types and constants of the top-k retention buffer
`default_nettype none

package tkrb_pkg;

    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int CNT_W   = 5;
    localparam int RANK_W  = 4;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic        [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic                      kind;
        logic signed [SCORE_W-1:0] score;
        logic        [TAG_W-1:0]   tag;
        logic        [RANK_W-1:0]  rank;
    } t_item;

    typedef struct packed {
        logic                      accepted;
        logic                      evicted;
        logic signed [SCORE_W-1:0] evicted_score;
        logic        [TAG_W-1:0]   evicted_tag;
        logic        [CNT_W-1:0]   occupancy;
        logic                      read_valid;
        logic signed [SCORE_W-1:0] read_score;
        logic        [TAG_W-1:0]   read_tag;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/top_k_retention_buffer.sv
// top level of the top-k retention buffer: sorted register array with parallel compares
// flow: an accepted word is held in the item register; its result word is registered
//   once the output register is free or being taken
// throughput: one word per cycle if unstalled, set by the single compare-and-shift pass
// reset: synchronous active low, empties the buffer and sets capacity to ten;
//   entry contents are not cleared
`default_nettype none

module top_k_retention_buffer #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [tkrb_pkg::CNT_W-1:0]            i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire                                   i_kind,
    input  wire  signed [tkrb_pkg::SCORE_W-1:0]   i_score,
    input  wire  [tkrb_pkg::TAG_W-1:0]            i_tag,
    input  wire  [tkrb_pkg::RANK_W-1:0]           i_rank,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_accepted,
    output logic                                  o_evicted,
    output logic signed [tkrb_pkg::SCORE_W-1:0]   o_evicted_score,
    output logic [tkrb_pkg::TAG_W-1:0]            o_evicted_tag,
    output logic [tkrb_pkg::CNT_W-1:0]            o_occupancy,
    output logic                                  o_read_valid,
    output logic signed [tkrb_pkg::SCORE_W-1:0]   o_read_score,
    output logic [tkrb_pkg::TAG_W-1:0]            o_read_tag
);

    localparam int CNT_W = tkrb_pkg::CNT_W;

    logic [CNT_W-1:0]  r_capacity;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_in_valid;
    tkrb_pkg::t_item   r_item;
    logic              r_out_valid;
    tkrb_pkg::t_result r_result, n_result;
    tkrb_pkg::t_entry  r_entries [MAX_ENTRIES];
    tkrb_pkg::t_entry  n_entries [MAX_ENTRIES];

    logic              advance;
    logic [CNT_W-1:0]  eff_cap;
    logic              full;
    logic              do_ins;
    logic [CNT_W-1:0]  ins_n;
    tkrb_pkg::t_entry  new_entry;
    tkrb_pkg::t_entry  last_entry;
    logic              gt   [MAX_ENTRIES];
    logic              keep [MAX_ENTRIES];

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign new_entry   = '{score: r_item.score, tag: r_item.tag};

    // effective capacity clamped to 1 .. MAX_ENTRIES
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if ({27'd0, r_capacity} > 32'(MAX_ENTRIES)) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = r_capacity;
        end
    end

    assign full = (r_count >= eff_cap);

    // lowest held entry
    always_comb begin
        last_entry = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ({27'd0, r_count} == 32'(i) + 32'd1) begin
                last_entry = r_entries[i];
            end
        end
    end

    // parallel compares against every slot
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            gt[i]   = $signed(r_item.score) > $signed(r_entries[i].score);
            keep[i] = (32'(i) < {27'd0, ins_n}) && !gt[i];
        end
    end

    always_comb begin
        if (full) begin
            ins_n  = r_count - CNT_W'(1);
            do_ins = (r_count != '0) && ($signed(r_item.score) > $signed(last_entry.score));
        end else begin
            ins_n  = r_count;
            do_ins = 1'b1;
        end
    end

    // sorted insert: slots before the new word hold, the slot at it takes it,
    // later slots up to the fill point shift down by one
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_entries[i] = r_entries[i];
        end
        if (r_item.kind == tkrb_pkg::KIND_INSERT && do_ins) begin
            if (!keep[0] && ins_n != '0) begin
                n_entries[0] = new_entry;
            end else if (ins_n == '0) begin
                n_entries[0] = new_entry;
            end
            for (int i = 1; i < MAX_ENTRIES; i++) begin
                if (32'(i) <= {27'd0, ins_n} && !keep[i]) begin
                    if (keep[i-1]) begin
                        n_entries[i] = new_entry;
                    end else begin
                        n_entries[i] = r_entries[i-1];
                    end
                end
            end
        end
    end

    always_comb begin
        n_result = '0;
        n_count  = r_count;
        if (r_item.kind == tkrb_pkg::KIND_INSERT) begin
            if (do_ins) begin
                n_result.accepted = 1'b1;
                if (full) begin
                    n_result.evicted       = 1'b1;
                    n_result.evicted_score = last_entry.score;
                    n_result.evicted_tag   = last_entry.tag;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end else begin
            if ({1'b0, r_item.rank} < r_count) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if ({28'd0, r_item.rank} == 32'(i)) begin
                        n_result.read_valid = 1'b1;
                        n_result.read_score = r_entries[i].score;
                        n_result.read_tag   = r_entries[i].tag;
                    end
                end
            end
        end
        n_result.occupancy = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= tkrb_pkg::CAP_RESET;
            r_count     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{kind: i_kind, score: i_score, tag: i_tag, rank: i_rank};
        end
        if (advance) begin
            r_result <= n_result;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_result.accepted;
    assign o_evicted       = r_result.evicted;
    assign o_evicted_score = r_result.evicted_score;
    assign o_evicted_tag   = r_result.evicted_tag;
    assign o_occupancy     = r_result.occupancy;
    assign o_read_valid    = r_result.read_valid;
    assign o_read_score    = r_result.read_score;
    assign o_read_tag      = r_result.read_tag;

endmodule

`default_nettype wire

>>> rtl/tkrb_checker.sv
// port-level checks of the top-k retention buffer and their bind
`default_nettype none

module tkrb_checker #(
    parameter int MAX_ENTRIES = 16
) (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  o_out_valid,
    input wire                                  i_out_ready,
    input wire                                  o_accepted,
    input wire                                  o_evicted,
    input wire signed [tkrb_pkg::SCORE_W-1:0]   o_evicted_score,
    input wire [tkrb_pkg::TAG_W-1:0]            o_evicted_tag,
    input wire [tkrb_pkg::CNT_W-1:0]            o_occupancy,
    input wire                                  o_read_valid
);

    // a stalled result word stays valid and keeps its occupancy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_occupancy))
        else $error("result word dropped or changed while stalled");

    // an eviction only comes with a kept insert and never with a read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted |-> o_accepted && !o_read_valid)
        else $error("eviction without acceptance");

    // no eviction means a zero evicted word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> o_evicted_score == '0 && o_evicted_tag == '0)
        else $error("evicted fields set without eviction");

    // occupancy never beyond the array and nonzero after a kept insert
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {27'd0, o_occupancy} <= 32'(MAX_ENTRIES)
            && (!o_accepted || o_occupancy != '0))
        else $error("occupancy out of range");

endmodule

bind top_k_retention_buffer tkrb_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_tkrb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_accepted      (o_accepted),
    .o_evicted       (o_evicted),
    .o_evicted_score (o_evicted_score),
    .o_evicted_tag   (o_evicted_tag),
    .o_occupancy     (o_occupancy),
    .o_read_valid    (o_read_valid)
);

`default_nettype wire
